// File: rtl/core/ipd_pkg.sv
// Shared types and constants for the IR pulse-distance decoder.
// No dependencies; imported by every module of the block.
`timescale 1ns / 1ps

package ipd_pkg;

  // Widths fixed by the stream payload
  localparam int TICK_W      = 16;
  localparam int IVL_W       = 8;
  localparam int CNT_W       = 7;
  localparam int FRAME_W     = 64;
  localparam int MATCH_W     = 32;
  localparam int IN_TDATA_W  = 24;
  localparam int OUT_TDATA_W = 72;

  localparam int CODE_BITS_DEFAULT = 64;
  localparam logic [MATCH_W-1:0] MATCH_CODE_RESET = 32'hA857_9F00;

  // Request kinds on in_tuser
  localparam logic REQ_EDGE    = 1'b0;
  localparam logic REQ_TIMEOUT = 1'b1;

  // Interval windows (ticks / 256)
  localparam logic [IVL_W-1:0] START_H_LO = 8'd7;
  localparam logic [IVL_W-1:0] START_H_HI = 8'd9;
  localparam logic [IVL_W-1:0] START_L_LO = 8'd3;
  localparam logic [IVL_W-1:0] START_L_HI = 8'd5;
  localparam logic [IVL_W-1:0] ONE_L_LO   = 8'd1;
  localparam logic [IVL_W-1:0] ONE_L_HI   = 8'd4;
  localparam logic [IVL_W-1:0] STOPA_L_LO = 8'd38;
  localparam logic [IVL_W-1:0] STOPA_L_HI = 8'd42;
  localparam logic [IVL_W-1:0] STOPB_L_LO = 8'd92;
  localparam logic [IVL_W-1:0] STOPB_L_HI = 8'd96;
  localparam logic [IVL_W-1:0] STOPC_L_LO = 8'd1;
  localparam logic [IVL_W-1:0] STOPC_L_HI = 8'd3;
  localparam logic [IVL_W-1:0] LONG_LO    = 8'd99;
  localparam logic [IVL_W-1:0] LONG_HI    = 8'd101;

  // One decoded input request
  typedef struct packed {
    logic             valid;
    logic             req_type;
    logic [IVL_W-1:0] ticks_hi;
    logic             pin_level;
  } ipd_item_t;

  // One frame result
  typedef struct packed {
    logic               valid;
    logic [FRAME_W-1:0] frame_code;
    logic [CNT_W-1:0]   bit_count;
    logic               code_match;
  } ipd_result_t;

  // Receiver status for checking
  typedef struct packed {
    logic armed;
    logic receiving;
  } ipd_status_t;

  function automatic logic in_window(input logic [IVL_W-1:0] v,
                                     input logic [IVL_W-1:0] lo,
                                     input logic [IVL_W-1:0] hi);
    return (v >= lo) && (v <= hi);
  endfunction

endpackage

// File: rtl/core/ipd_in_stage.sv
// Input register of the IR decoder: captures one request from the stream.
// Depends on ipd_pkg.
`timescale 1ns / 1ps

module ipd_in_stage
  import ipd_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_tvalid,
  output logic                  in_tready,
  input  logic [IN_TDATA_W-1:0] in_tdata,
  input  logic                  in_tuser,
  input  logic                  adv_ok,
  output ipd_item_t             item
);

  logic             valid_r, valid_nxt;
  logic             req_r;
  logic [IVL_W-1:0] ticks_r;
  logic             level_r;
  logic             take;

  assign in_tready = !valid_r || adv_ok;
  assign take      = in_tvalid && in_tready;

  // Hold the request until the decode stage consumes it
  always_comb begin
    valid_nxt = valid_r;
    if (take) begin
      valid_nxt = 1'b1;
    end else if (adv_ok) begin
      valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  // Capture payload; only the upper byte of the tick count is kept
  always_ff @(posedge clk) begin
    if (take) begin
      req_r   <= in_tuser;
      ticks_r <= in_tdata[TICK_W-1:TICK_W-IVL_W];
      level_r <= in_tdata[TICK_W];
    end
  end

  assign item.valid     = valid_r;
  assign item.req_type  = req_r;
  assign item.ticks_hi  = ticks_r;
  assign item.pin_level = level_r;

endmodule

// File: rtl/core/ipd_frame_fsm.sv
// Frame receiver of the IR decoder: pair classification, bit shift register,
// frame result. Depends on ipd_pkg.
`timescale 1ns / 1ps

module ipd_frame_fsm
  import ipd_pkg::*;
#(
  parameter int CODE_BITS = CODE_BITS_DEFAULT
) (
  input  logic               clk,
  input  logic               rst_n,
  input  ipd_item_t          item,
  input  logic               adv_ok,
  input  logic [MATCH_W-1:0] match_code,
  output ipd_result_t        res,
  output ipd_status_t        status
);

  localparam logic [CNT_W-1:0] CNT_MAX = CNT_W'(CODE_BITS);

  logic                 armed_r, armed_nxt;
  logic                 recv_r, recv_nxt;
  logic [IVL_W-1:0]     first_r, first_nxt;
  logic [CNT_W-1:0]     cnt_r, cnt_nxt;
  logic [CODE_BITS-1:0] code_r, code_nxt;
  logic [FRAME_W-1:0]   code_ext;
  logic                 fire, pair;
  logic                 is_zero, is_one, is_stop, is_start, is_long;
  logic [IVL_W-1:0]     h, l;

  assign fire = item.valid && adv_ok;
  assign h    = first_r;
  assign l    = item.ticks_hi;
  assign pair = fire && (item.req_type == REQ_EDGE) && armed_r && !item.pin_level;

  // Classify the high/low interval pair
  assign is_zero  = (h == '0) && (l == '0);
  assign is_one   = (h == '0) && in_window(l, ONE_L_LO, ONE_L_HI);
  assign is_stop  = ((h == '0) && in_window(l, STOPA_L_LO, STOPA_L_HI)) ||
                    ((h == '0) && in_window(l, STOPB_L_LO, STOPB_L_HI)) ||
                    (in_window(h, START_H_LO, START_H_HI) &&
                     in_window(l, STOPC_L_LO, STOPC_L_HI));
  assign is_start = in_window(h, START_H_LO, START_H_HI) &&
                    in_window(l, START_L_LO, START_L_HI);
  assign is_long  = in_window(h, LONG_LO, LONG_HI) || in_window(l, LONG_LO, LONG_HI);

  assign code_ext = FRAME_W'(code_r);

  // Advance receiver state for one request
  always_comb begin
    armed_nxt = armed_r;
    recv_nxt  = recv_r;
    first_nxt = first_r;
    cnt_nxt   = cnt_r;
    code_nxt  = code_r;
    if (fire) begin
      if (item.req_type == REQ_TIMEOUT) begin
        armed_nxt = 1'b0;
        recv_nxt  = 1'b0;
      end else if (!armed_r) begin
        armed_nxt = 1'b1;
      end else if (item.pin_level) begin
        first_nxt = l;
      end else begin
        if (recv_r) begin
          if ((is_zero || is_one) && (cnt_r < CNT_MAX)) begin
            for (int i = 0; i < CODE_BITS; i++) begin
              if (is_one && !is_zero && (cnt_r == CNT_W'(i))) begin
                code_nxt[i] = 1'b1;
              end
            end
            cnt_nxt = cnt_r + 1'b1;
          end else if (!is_zero && !is_one && is_stop) begin
            recv_nxt = 1'b0;
          end
        end else if (is_start) begin
          recv_nxt = 1'b1;
          code_nxt = '0;
          cnt_nxt  = '0;
        end
        if (is_long) begin
          armed_nxt = 1'b0;
          recv_nxt  = 1'b0;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      armed_r <= 1'b0;
      recv_r  <= 1'b0;
      first_r <= '0;
      cnt_r   <= '0;
      code_r  <= '0;
    end else begin
      armed_r <= armed_nxt;
      recv_r  <= recv_nxt;
      first_r <= first_nxt;
      cnt_r   <= cnt_nxt;
      code_r  <= code_nxt;
    end
  end

  // Emit the frame on a stop pair
  assign res.valid      = pair && recv_r && !is_zero && !is_one && is_stop;
  assign res.frame_code = code_ext;
  assign res.bit_count  = cnt_r;
  assign res.code_match = (code_ext[MATCH_W-1:0] == match_code);

  assign status.armed     = armed_r;
  assign status.receiving = recv_r;

endmodule

// File: rtl/core/ipd_out_stage.sv
// Result register of the IR decoder: holds one frame result for the stream.
// Depends on ipd_pkg.
`timescale 1ns / 1ps

module ipd_out_stage
  import ipd_pkg::*;
(
  input  logic                   clk,
  input  logic                   rst_n,
  input  ipd_result_t            res,
  output logic                   adv_ok,
  output logic                   out_tvalid,
  input  logic                   out_tready,
  output logic [OUT_TDATA_W-1:0] out_tdata
);

  logic                   valid_r, valid_nxt;
  logic [OUT_TDATA_W-1:0] data_r;

  // Decode may advance when the register is empty or draining
  assign adv_ok = !valid_r || out_tready;

  always_comb begin
    valid_nxt = valid_r;
    if (res.valid) begin
      valid_nxt = 1'b1;
    end else if (out_tready) begin
      valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  // Load the packed result
  always_ff @(posedge clk) begin
    if (res.valid) begin
      data_r <= {res.code_match, res.bit_count, res.frame_code};
    end
  end

  assign out_tvalid = valid_r;
  assign out_tdata  = data_r;

endmodule

// File: rtl/core/ir_pulse_distance_decoder_top.sv
// IR pulse-distance decoder top level: input register, frame receiver,
// result register, match-code register. Depends on ipd_pkg and submodules.
// A frame-ending edge passes the input register, then the result register, to out_tvalid.
// Throughput: one request per cycle while a held result is not stalled by out_tready.
// Reset (rst_n, synchronous): idle, not receiving, counters and code cleared,
// match code 0xA8579F00. cfg_ready is always high.
`timescale 1ns / 1ps

module ir_pulse_distance_decoder_top
  import ipd_pkg::*;
#(
  parameter int CODE_BITS = CODE_BITS_DEFAULT
) (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   in_tvalid,
  output logic                   in_tready,
  input  logic [IN_TDATA_W-1:0]  in_tdata,   // [15:0] elapsed_ticks, [16] pin_level
  input  logic                   in_tuser,   // [0] req_type
  output logic                   out_tvalid,
  input  logic                   out_tready,
  output logic [OUT_TDATA_W-1:0] out_tdata,  // [63:0] frame_code, [70:64] bit_count,
                                             // [71] code_match
  input  logic                   cfg_valid,
  output logic                   cfg_ready,
  input  logic [MATCH_W-1:0]     cfg_data
);

  ipd_item_t          item;
  ipd_result_t        res;
  ipd_status_t        status;
  logic               adv_ok;
  logic [MATCH_W-1:0] match_r;

  // Match-code register
  assign cfg_ready = 1'b1;
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      match_r <= MATCH_CODE_RESET;
    end else if (cfg_valid && cfg_ready) begin
      match_r <= cfg_data;
    end
  end

  ipd_in_stage u_in (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .in_tuser  (in_tuser),
    .adv_ok    (adv_ok),
    .item      (item)
  );

  ipd_frame_fsm #(
    .CODE_BITS (CODE_BITS)
  ) u_fsm (
    .clk        (clk),
    .rst_n      (rst_n),
    .item       (item),
    .adv_ok     (adv_ok),
    .match_code (match_r),
    .res        (res),
    .status     (status)
  );

  ipd_out_stage u_out (
    .clk        (clk),
    .rst_n      (rst_n),
    .res        (res),
    .adv_ok     (adv_ok),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata)
  );

  // Receiving never happens while disarmed
  a_recv_armed: assert property (@(posedge clk) disable iff (!rst_n)
    status.receiving |-> status.armed)
    else $error("receiving while not armed");

  // Bit count never exceeds the code width
  a_cnt_max: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> (out_tdata[FRAME_W+CNT_W-1:FRAME_W] <= CNT_W'(CODE_BITS)))
    else $error("bit count above code width");

  // Match flag agrees with the delivered code
  a_match: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> (out_tdata[OUT_TDATA_W-1] == (out_tdata[MATCH_W-1:0] == match_r)))
    else $error("code match flag inconsistent");

  // A frame result only follows an edge request
  a_res_src: assert property (@(posedge clk) disable iff (!rst_n)
    res.valid |-> (item.valid && (item.req_type == REQ_EDGE) && !item.pin_level))
    else $error("result without low edge");

endmodule

// File: tb/sv/ipd_frame_checker.sv
// Frame checker for the IR pulse-distance decoder: watches the request, result
// and match-code channels, predicts each decoded frame and compares it.
// Depends on ipd_pkg for widths, request kinds and interval windows.
`timescale 1ns / 1ps

module ipd_frame_checker
  import ipd_pkg::*;
(
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   in_tvalid,
  input  logic                   in_tready,
  input  logic [IN_TDATA_W-1:0]  in_tdata,   // [15:0] elapsed_ticks, [16] pin_level
  input  logic                   in_tuser,   // [0] req_type
  input  logic                   out_tvalid,
  input  logic                   out_tready,
  input  logic [OUT_TDATA_W-1:0] out_tdata,  // [63:0] frame_code, [70:64] bit_count,
                                             // [71] code_match
  input  logic                   cfg_valid,
  input  logic                   cfg_ready,
  input  logic [MATCH_W-1:0]     cfg_data,
  output int                     mismatches,
  output int                     pending,
  output int                     frames_checked,
  output int                     frames_hit
);

  localparam int CODE_LEN    = CODE_BITS_DEFAULT;
  localparam int MAX_REPORTS = 40;

  typedef struct packed {
    logic [FRAME_W-1:0] code;
    logic [CNT_W-1:0]   nbits;
    logic               hit;
  } frame_t;

  frame_t expected_frames[$];

  // Shadow of the receiver state and the match register
  logic [MATCH_W-1:0] match_reg = MATCH_CODE_RESET;
  logic               armed_q   = 1'b0;
  logic               rx_active = 1'b0;
  logic [IVL_W-1:0]   hi_ivl    = '0;
  logic [CNT_W-1:0]   bits_rcvd = '0;
  logic [FRAME_W-1:0] code_sr   = '0;

  int fail_count  = 0;
  int check_count = 0;
  int hit_count   = 0;

  assign mismatches     = fail_count;
  assign pending        = expected_frames.size();
  assign frames_checked = check_count;
  assign frames_hit     = hit_count;

  function automatic bit in_span(input logic [IVL_W-1:0] v, input logic [IVL_W-1:0] lo,
                                 input logic [IVL_W-1:0] hi);
    return (v >= lo) && (v <= hi);
  endfunction

  // Print one line per mismatch (capped) and count every one
  task automatic report(input string what, input logic [FRAME_W-1:0] got,
                        input logic [FRAME_W-1:0] want);
    fail_count++;
    if (fail_count <= MAX_REPORTS)
      $display("[%0t] mismatch on %s: got %h, want %h", $time, what, got, want);
  endtask

  // Append one data bit; drop it once the code is full
  task automatic shift_in(input logic one);
    if (bits_rcvd < CODE_LEN) begin
      if (one)
        code_sr[bits_rcvd[$clog2(FRAME_W)-1:0]] = 1'b1;
      bits_rcvd = bits_rcvd + 1'b1;
    end
  endtask

  // Advance the shadow receiver by one request; queue a frame on a stop pair
  task automatic decode_request(input logic kind, input logic [IVL_W-1:0] l,
                                input logic lvl);
    frame_t f;
    logic [IVL_W-1:0] h;
    if (kind == REQ_TIMEOUT) begin
      armed_q   = 1'b0;
      rx_active = 1'b0;
      return;
    end
    // first edge after idle only arms
    if (!armed_q) begin
      armed_q = 1'b1;
      return;
    end
    if (lvl) begin
      hi_ivl = l;
      return;
    end
    h = hi_ivl;
    if (rx_active) begin
      if (h == '0 && l == '0) begin
        shift_in(1'b0);
      end else if (h == '0 && in_span(l, ONE_L_LO, ONE_L_HI)) begin
        shift_in(1'b1);
      end else if ((h == '0 && in_span(l, STOPA_L_LO, STOPA_L_HI)) ||
                   (h == '0 && in_span(l, STOPB_L_LO, STOPB_L_HI)) ||
                   (in_span(h, START_H_LO, START_H_HI) &&
                    in_span(l, STOPC_L_LO, STOPC_L_HI))) begin
        rx_active = 1'b0;
        f.code    = code_sr;
        f.nbits   = bits_rcvd;
        f.hit     = (code_sr[MATCH_W-1:0] == match_reg);
        expected_frames.push_back(f);
      end
    end else if (in_span(h, START_H_LO, START_H_HI) && in_span(l, START_L_LO, START_L_HI)) begin
      rx_active = 1'b1;
      code_sr   = '0;
      bits_rcvd = '0;
    end
    // long interval on either half drops back to idle
    if (in_span(h, LONG_LO, LONG_HI) || in_span(l, LONG_LO, LONG_HI)) begin
      armed_q   = 1'b0;
      rx_active = 1'b0;
    end
  endtask

  always @(posedge clk) begin
    frame_t want;
    if (!rst_n) begin
      match_reg = MATCH_CODE_RESET;
      armed_q   = 1'b0;
      rx_active = 1'b0;
      hi_ivl    = '0;
      bits_rcvd = '0;
      code_sr   = '0;
      expected_frames.delete();
    end else begin
      if (cfg_valid && cfg_ready)
        match_reg = cfg_data;
      // compare each delivered frame with the oldest prediction
      if (out_tvalid && out_tready) begin
        if (expected_frames.size() == 0) begin
          report("frame with none expected", out_tdata[FRAME_W-1:0], '0);
        end else begin
          want = expected_frames.pop_front();
          check_count++;
          if (want.hit)
            hit_count++;
          if (out_tdata[FRAME_W-1:0] !== want.code)
            report("frame_code", out_tdata[FRAME_W-1:0], want.code);
          if (out_tdata[FRAME_W +: CNT_W] !== want.nbits)
            report("bit_count", FRAME_W'(out_tdata[FRAME_W +: CNT_W]), FRAME_W'(want.nbits));
          if (out_tdata[FRAME_W+CNT_W] !== want.hit)
            report("code_match", FRAME_W'(out_tdata[FRAME_W+CNT_W]), FRAME_W'(want.hit));
        end
      end
      if (in_tvalid && in_tready)
        decode_request(in_tuser, in_tdata[TICK_W-1:TICK_W-IVL_W], in_tdata[TICK_W]);
    end
  end

endmodule

// File: tb/sv/tb.sv
// Testbench top for ir_pulse_distance_decoder_top: clock, reset, request and
// match-code stimulus, result back-pressure, watchdog and final verdict.
// Depends on ipd_pkg, the decoder RTL and ipd_frame_checker.
`timescale 1ns / 1ps

module tb;
  import ipd_pkg::*;

  localparam int PHASE_ITEMS    = 480;
  localparam int HOLD_CYCLES    = 250;
  localparam int SETTLE_CYCLES  = 4;
  localparam int END_CYCLES     = 10;
  localparam int WATCHDOG_LIMIT = 3000;

  // Boundaries of the interval windows and a few values just outside them
  localparam logic [IVL_W-1:0] EDGE_IVL [16] = '{
    8'd0, START_H_LO, START_H_HI, START_L_LO, START_L_HI, ONE_L_LO, ONE_L_HI,
    STOPA_L_LO, STOPA_L_HI, STOPB_L_LO, STOPB_L_HI, LONG_LO, LONG_HI,
    START_H_LO - 8'd1, STOPA_L_HI + 8'd1, 8'hFF
  };

  logic                   clk        = 1'b0;
  logic                   rst_n      = 1'b0;
  logic                   in_tvalid  = 1'b0;
  logic                   in_tready;
  logic [IN_TDATA_W-1:0]  in_tdata   = '0;   // [15:0] elapsed_ticks, [16] pin_level
  logic                   in_tuser   = 1'b0; // [0] req_type
  logic                   out_tvalid;
  logic                   out_tready = 1'b0;
  logic [OUT_TDATA_W-1:0] out_tdata;         // [63:0] frame_code, [70:64] bit_count,
                                             // [71] code_match
  logic                   cfg_valid  = 1'b0;
  logic                   cfg_ready;
  logic [MATCH_W-1:0]     cfg_data   = '0;

  int mismatches, pending, frames_checked, frames_hit;

  int send_idle_pct  = 0;
  int recv_stall_pct = 0;
  int hold_reqs      = 0;
  int hold_seen      = 0;
  int hold_left      = 0;
  int requests_sent  = 0;
  int idle_cycles    = 0;
  int match_settings = 1;
  logic [MATCH_W-1:0] cur_match = MATCH_CODE_RESET;

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  ir_pulse_distance_decoder_top u_top (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_data   (cfg_data)
  );

  ipd_frame_checker u_checker (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_tvalid      (in_tvalid),
    .in_tready      (in_tready),
    .in_tdata       (in_tdata),
    .in_tuser       (in_tuser),
    .out_tvalid     (out_tvalid),
    .out_tready     (out_tready),
    .out_tdata      (out_tdata),
    .cfg_valid      (cfg_valid),
    .cfg_ready      (cfg_ready),
    .cfg_data       (cfg_data),
    .mismatches     (mismatches),
    .pending        (pending),
    .frames_checked (frames_checked),
    .frames_hit     (frames_hit)
  );

  // Result side: long hold-off on request, otherwise random stalls
  always @(posedge clk) begin
    if (!rst_n) begin
      out_tready <= 1'b0;
    end else if (hold_seen != hold_reqs) begin
      hold_seen = hold_reqs;
      hold_left = HOLD_CYCLES;
      out_tready <= 1'b0;
    end else if (hold_left != 0) begin
      hold_left--;
      out_tready <= 1'b0;
    end else begin
      out_tready <= ($urandom_range(99) >= recv_stall_pct);
    end
  end

  // Watchdog: end the run after too many cycles without any handshake
  always @(posedge clk) begin
    if ((in_tvalid && in_tready) || (out_tvalid && out_tready) || (cfg_valid && cfg_ready) ||
        !rst_n)
      idle_cycles <= 0;
    else
      idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("watchdog: no handshake for %0d cycles, %0d frames pending",
               idle_cycles, pending);
      $display("end of test: mismatches");
      $finish;
    end
  end

  function automatic logic [IVL_W-1:0] pick_ivl(input int lo, input int hi);
    return IVL_W'($urandom_range(hi, lo));
  endfunction

  // Offer one request, idling first as the pacing profile says
  task automatic send_req(input logic kind, input logic [TICK_W-1:0] ticks, input logic lvl);
    while ($urandom_range(99) < send_idle_pct) begin
      in_tvalid <= 1'b0;
      @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tuser  <= kind;
    in_tdata  <= {{(IN_TDATA_W - TICK_W - 1){1'b0}}, lvl, ticks};
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    requests_sent++;
  endtask

  task automatic send_edge(input logic [IVL_W-1:0] ivl, input logic lvl);
    send_req(REQ_EDGE, {ivl, 8'($urandom)}, lvl);
  endtask

  task automatic send_pair(input logic [IVL_W-1:0] h, input logic [IVL_W-1:0] l);
    send_edge(h, 1'b1);
    send_edge(l, 1'b0);
  endtask

  task automatic send_timeout();
    send_req(REQ_TIMEOUT, 16'($urandom), 1'($urandom));
  endtask

  task automatic send_start();
    send_pair(pick_ivl(START_H_LO, START_H_HI), pick_ivl(START_L_LO, START_L_HI));
  endtask

  task automatic send_bit(input logic one);
    send_pair(8'd0, one ? pick_ivl(ONE_L_LO, ONE_L_HI) : 8'd0);
  endtask

  task automatic send_stop();
    case ($urandom_range(2))
      0:       send_pair(8'd0, pick_ivl(STOPA_L_LO, STOPA_L_HI));
      1:       send_pair(8'd0, pick_ivl(STOPB_L_LO, STOPB_L_HI));
      default: send_pair(pick_ivl(START_H_LO, START_H_HI), pick_ivl(STOPC_L_LO, STOPC_L_HI));
    endcase
  endtask

  // Well-formed frame; optionally reset and arm first, low bits from the match code
  task automatic send_frame(input int nbits, input bit use_match, input bit prefix);
    logic b;
    if (prefix) begin
      send_timeout();
      send_edge(8'($urandom), 1'($urandom));
    end
    send_start();
    for (int i = 0; i < nbits; i++) begin
      b = (use_match && i < MATCH_W) ? cur_match[i] : 1'($urandom);
      // now and then skip the high edge and reuse the stale zero interval
      if (i == 0 || $urandom_range(9) != 0)
        send_edge(8'd0, 1'b1);
      send_edge(b ? pick_ivl(ONE_L_LO, ONE_L_HI) : 8'd0, 1'b0);
    end
    send_stop();
  endtask

  // Start a frame and break it off in one of several ways
  task automatic send_broken_frame();
    send_start();
    repeat ($urandom_range(5)) send_bit(1'($urandom));
    case ($urandom_range(3))
      0:       send_timeout();
      1:       send_pair(8'd0, pick_ivl(LONG_LO, LONG_HI));
      2:       send_pair(pick_ivl(LONG_LO, LONG_HI), 8'($urandom));
      default: begin
        send_start();
        send_stop();
      end
    endcase
  endtask

  task automatic send_noise();
    logic [IVL_W-1:0] ivl;
    repeat ($urandom_range(6, 1)) begin
      ivl = $urandom_range(1) ? 8'($urandom) : EDGE_IVL[4'($urandom_range(15))];
      send_req(($urandom_range(99) < 15) ? REQ_TIMEOUT : REQ_EDGE, {ivl, 8'($urandom)},
               1'($urandom));
    end
  endtask

  task automatic send_random_unit();
    int pick;
    int sz;
    pick = $urandom_range(99);
    sz   = $urandom_range(99);
    if (pick < 72) begin
      if (sz < 4)
        send_frame($urandom_range(70, 62), 1'($urandom), $urandom_range(99) < 35);
      else if (sz < 18)
        send_frame($urandom_range(48, MATCH_W), 1'b1, $urandom_range(99) < 35);
      else
        send_frame($urandom_range(24), 1'b0, $urandom_range(99) < 35);
    end else if (pick < 86) begin
      send_broken_frame();
    end else begin
      send_noise();
    end
  endtask

  // Hold requests until every predicted frame is out, then let the block settle
  task automatic wait_drained();
    in_tvalid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_match(input logic [MATCH_W-1:0] value);
    cfg_valid <= 1'b1;
    cfg_data  <= value;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    cfg_valid <= 1'b0;
    cur_match = value;
    match_settings++;
  endtask

  initial begin
    int phase_end;
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed: idle edge, timeouts, each pair kind and the corner cases
    send_req(REQ_EDGE, 16'hFFFF, 1'b1);       // arms only
    send_req(REQ_TIMEOUT, 16'hFFFF, 1'b1);    // back to idle
    send_req(REQ_EDGE, 16'h0000, 1'b0);       // arms again
    send_pair(8'd8, 8'd4);                    // start
    send_pair(8'd0, 8'd0);                    // zero bit
    send_pair(8'd0, 8'd1);                    // one bit
    send_edge(8'd4, 1'b0);                    // stale zero high interval, one bit
    send_pair(8'd8, 8'd4);                    // start while receiving: ignored
    send_pair(8'd0, 8'd40);                   // first stop kind
    send_pair(8'd7, 8'd3);
    send_pair(8'd0, 8'd94);                   // second stop kind, empty frame
    send_pair(8'd9, 8'd5);
    send_edge(8'd1, 1'b0);                    // third stop kind via stale high interval
    send_pair(8'd100, 8'd3);                  // long interval
    wait_drained();

    // Random phases, each with its own pacing and match code
    for (int phase = 0; phase < 4; phase++) begin
      case (phase)
        0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
        1: begin send_idle_pct = 58; recv_stall_pct = 0;  write_match('0); end
        2: begin send_idle_pct = 0;  recv_stall_pct = 58; write_match('1); end
        default: begin
          send_idle_pct = 30; recv_stall_pct = 30;
          write_match(MATCH_W'($urandom));
        end
      endcase
      phase_end = requests_sent + PHASE_ITEMS;
      // back-pressure burst: result side holds off while short frames keep coming
      if (phase == 0) begin
        hold_reqs++;
        repeat (6) send_frame($urandom_range(2), 1'b0, 1'b1);
        wait_drained();
      end
      while (requests_sent < phase_end)
        send_random_unit();
      wait_drained();
    end

    in_tvalid <= 1'b0;
    while (pending != 0) @(posedge clk);
    repeat (END_CYCLES) @(posedge clk);
    $display("run covered %0d requests and %0d decoded frames, %0d of them code matches",
             requests_sent, frames_checked, frames_hit);
    $display("over four pacing profiles and %0d match-code settings", match_settings);
    if (mismatches == 0 && pending == 0)
      $display("end of test: clean");
    else
      $display("end of test: mismatches");
    $finish;
  end

endmodule
